// ----- rtl/core/bis_pkg.sv -----
// Shared types and constants of the bilinear image scaler.
package bis_pkg;

  // Fixed field widths
  localparam int unsigned SampleBits = 16;
  localparam int unsigned CoordBits  = 10;
  localparam int unsigned IdxMaxBits = 12;  // source index, up to 4096 rows/cols
  localparam int unsigned WtMaxBits  = 17;  // weight up to 1.0 at 16 bits
  localparam int unsigned SizeBits   = 13;

  typedef enum logic [2:0] {
    CfgSrcRows = 3'd0,
    CfgSrcCols = 3'd1,
    CfgDstRows = 3'd2,
    CfgDstCols = 3'd3,
    CfgRowStep = 3'd4,
    CfgColStep = 3'd5,
    CfgSingle  = 3'd6
  } cfg_idx_e;

  typedef enum logic {
    CmdWrite   = 1'b0,
    CmdRequest = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [8:0]  source_rows;
    logic [8:0]  source_cols;
    logic [10:0] target_rows;
    logic [10:0] target_cols;
    logic [23:0] row_step;
    logic [23:0] col_step;
    logic        single_channel;
  } cfg_t;

  typedef struct packed {
    logic                  command;
    logic [CoordBits-1:0]  pixel_row;
    logic [CoordBits-1:0]  pixel_col;
    logic [SampleBits-1:0] sample_a;
    logic [SampleBits-1:0] sample_b;
    logic [SampleBits-1:0] sample_c;
  } item_t;

  typedef struct packed {
    logic [CoordBits-1:0]  out_row;
    logic [CoordBits-1:0]  out_col;
    logic [SampleBits-1:0] out_a;
    logic [SampleBits-1:0] out_b;
    logic [SampleBits-1:0] out_c;
    logic                  range_error;
  } result_t;

  // Classified work handed from front to back
  typedef struct packed {
    logic                  is_write;
    logic                  err;
    logic [CoordBits-1:0]  row;
    logic [CoordBits-1:0]  col;
    logic [SampleBits-1:0] a;
    logic [SampleBits-1:0] b;
    logic [SampleBits-1:0] c;
    logic [IdxMaxBits-1:0] r0;
    logic [IdxMaxBits-1:0] c0;
    logic [WtMaxBits-1:0]  wr;
    logic [WtMaxBits-1:0]  wc;
  } job_t;

endpackage

// ----- rtl/core/bis_front.sv -----
// Front end: accepts beats, checks range and maps coordinates to source index and weight.
module bis_front #(
  parameter int unsigned MAX_SOURCE_ROWS = 256,
  parameter int unsigned MAX_SOURCE_COLS = 256,
  parameter int unsigned WEIGHT_BITS     = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  bis_pkg::item_t item_i,
  input  bis_pkg::cfg_t  cfg_i,
  input  logic           q_full_i,
  output logic           push_o,
  output bis_pkg::job_t  job_o
);
  import bis_pkg::*;

  localparam logic [WtMaxBits-1:0] WtOne = WtMaxBits'(1) << WEIGHT_BITS;
  localparam logic [17:0]          WtRnd = 18'(1) << (16 - WEIGHT_BITS);

  // Clamp a configured size to 2..max
  function automatic logic [SizeBits-1:0] clamp_size(input logic [8:0] v,
                                                     input logic [SizeBits-1:0] maxv);
    logic [SizeBits-1:0] w;
    w = SizeBits'(v);
    if (w < SizeBits'(2)) return SizeBits'(2);
    if (w > maxv) return maxv;
    return w;
  endfunction

  // Split (d+0.5)*step - 0.5 into index and weight, clamping at both edges
  function automatic logic [IdxMaxBits+WtMaxBits-1:0] map_coord(
      input logic [34:0] prod, input logic [SizeBits-1:0] size);
    logic [35:0] t;
    logic [17:0] ip;
    logic [16:0] fr;
    logic [17:0] rsum;
    t    = {1'b0, prod} - 36'd65536;
    ip   = t[34:17];
    fr   = t[16:0];
    rsum = {1'b0, fr} + WtRnd;
    if (t[35]) return '0;
    if ({1'b0, ip} + 19'd1 >= 19'(size))
      return {IdxMaxBits'(size - SizeBits'(2)), WtOne};
    return {ip[IdxMaxBits-1:0], WtMaxBits'(rsum >> (17 - WEIGHT_BITS))};
  endfunction

  logic        s0_v_q, s0_v_d;
  item_t       s0_item_q;
  logic        s0_err_q;
  logic [34:0] s0_pr_q, s0_pc_q;
  logic        s1_v_q, s1_v_d;
  job_t        s1_job_q, s1_job_d;
  logic        en0, en1;
  logic [SizeBits-1:0] srows, scols;
  logic [IdxMaxBits+WtMaxBits-1:0] mr, mc;

  // Stall control
  assign en1    = !s1_v_q || !q_full_i;
  assign en0    = !s0_v_q || en1;
  assign busy   = !en0;
  assign push_o = s1_v_q;
  assign job_o  = s1_job_q;
  assign s0_v_d = en0 ? start : s0_v_q;
  assign s1_v_d = en1 ? s0_v_q : s1_v_q;

  // Stage 0: capture beat, range check, step products
  always_ff @(posedge clk_i) begin
    if (en0 && start) begin
      s0_item_q <= item_i;
      s0_err_q  <= ({1'b0, item_i.pixel_row} >= cfg_i.target_rows) ||
                   ({1'b0, item_i.pixel_col} >= cfg_i.target_cols);
      s0_pr_q   <= 35'({item_i.pixel_row, 1'b1} * cfg_i.row_step);
      s0_pc_q   <= 35'({item_i.pixel_col, 1'b1} * cfg_i.col_step);
    end
  end

  // Stage 1: coordinate mapping
  always_comb begin
    srows = clamp_size(cfg_i.source_rows, SizeBits'(MAX_SOURCE_ROWS));
    scols = clamp_size(cfg_i.source_cols, SizeBits'(MAX_SOURCE_COLS));
    mr    = map_coord(s0_pr_q, srows);
    mc    = map_coord(s0_pc_q, scols);
    s1_job_d.is_write = (s0_item_q.command == CmdWrite);
    s1_job_d.err      = s0_err_q;
    s1_job_d.row      = s0_item_q.pixel_row;
    s1_job_d.col      = s0_item_q.pixel_col;
    s1_job_d.a        = s0_item_q.sample_a;
    s1_job_d.b        = s0_item_q.sample_b;
    s1_job_d.c        = s0_item_q.sample_c;
    s1_job_d.r0       = mr[IdxMaxBits+WtMaxBits-1:WtMaxBits];
    s1_job_d.wr       = mr[WtMaxBits-1:0];
    s1_job_d.c0       = mc[IdxMaxBits+WtMaxBits-1:WtMaxBits];
    s1_job_d.wc       = mc[WtMaxBits-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en1 && s0_v_q) begin
      s1_job_q <= s1_job_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q <= 1'b0;
      s1_v_q <= 1'b0;
    end else begin
      s0_v_q <= s0_v_d;
      s1_v_q <= s1_v_d;
    end
  end

endmodule

// ----- rtl/core/bis_queue.sv -----
// Two-entry job queue between front and back.
module bis_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bis_pkg::job_t job_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output bis_pkg::job_t job_o
);
  import bis_pkg::*;

  job_t       mem_q [2];
  logic       wptr_q, wptr_d, rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign job_o   = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ----- rtl/core/bis_back.sv -----
// Back end: four-bank frame store, neighbor fetch and bilinear blend.
module bis_back #(
  parameter int unsigned MAX_SOURCE_ROWS = 256,
  parameter int unsigned MAX_SOURCE_COLS = 256,
  parameter int unsigned WEIGHT_BITS     = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             empty_i,
  input  bis_pkg::job_t    job_i,
  output logic             pop_o,
  input  logic             single_i,
  output logic             res_strobe_o,
  output bis_pkg::result_t res_o
);
  import bis_pkg::*;

  localparam int unsigned RB    = $clog2(MAX_SOURCE_ROWS);
  localparam int unsigned CB    = $clog2(MAX_SOURCE_COLS);
  localparam int unsigned RH    = (RB > 1) ? RB - 1 : 1;
  localparam int unsigned CH    = (CB > 1) ? CB - 1 : 1;
  localparam int unsigned AB    = RH + CH;
  localparam int unsigned Depth = 1 << AB;
  localparam int unsigned WB    = WEIGHT_BITS + 1;
  localparam int unsigned TB    = SampleBits + WEIGHT_BITS;
  localparam int unsigned SB    = SampleBits + 2 * WEIGHT_BITS;
  localparam int unsigned PB    = 3 * SampleBits;
  localparam logic [WB-1:0] WOne = WB'(1) << WEIGHT_BITS;
  localparam logic [SB-1:0] Half = SB'(1) << (2 * WEIGHT_BITS - 1);

  logic [AB-1:0] addr   [4];
  logic          wen    [4];
  logic [PB-1:0] rdata_q[4];
  logic          wr_ok;
  logic [IdxMaxBits-1:0] r1, c1;

  // B0 meta
  logic                 b0_v_q;
  logic                 b0_err_q, b0_rp_q, b0_cp_q;
  logic [CoordBits-1:0] b0_row_q, b0_col_q;
  logic [WB-1:0]        b0_wr_q, b0_wc_q;
  // B1 partial sums
  logic                 b1_v_q, b1_err_q;
  logic [CoordBits-1:0] b1_row_q, b1_col_q;
  logic [WB-1:0]        b1_wr_q;
  logic [TB-1:0]        top_q[3], bot_q[3], top_d[3], bot_d[3];
  logic [SampleBits-1:0] blend[3];
  // Output
  logic    strobe_q;
  result_t res_q, res_d;

  assign pop_o = !empty_i;
  assign wr_ok = ({3'b0, job_i.row} < 13'(MAX_SOURCE_ROWS)) &&
                 ({3'b0, job_i.col} < 13'(MAX_SOURCE_COLS));
  assign r1 = job_i.r0 + IdxMaxBits'(1);
  assign c1 = job_i.c0 + IdxMaxBits'(1);

  // Bank k holds row parity k[1], column parity k[0]
  for (genvar k = 0; k < 4; k++) begin : g_bank
    logic [PB-1:0]        mem [Depth];
    logic [IdxMaxBits-1:0] rsel, csel;

    always_comb begin
      rsel = (job_i.r0[0] == k[1]) ? job_i.r0 : r1;
      csel = (job_i.c0[0] == k[0]) ? job_i.c0 : c1;
      wen[k] = pop_o && job_i.is_write && wr_ok &&
               (job_i.row[0] == k[1]) && (job_i.col[0] == k[0]);
      if (job_i.is_write) begin
        addr[k] = {RH'({2'b0, job_i.row} >> 1), CH'({2'b0, job_i.col} >> 1)};
      end else begin
        addr[k] = {RH'(rsel >> 1), CH'(csel >> 1)};
      end
    end

    always_ff @(posedge clk_i) begin
      if (wen[k]) begin
        mem[addr[k]] <= {job_i.c, job_i.b, job_i.a};
      end
    end

    always_ff @(posedge clk_i) begin
      rdata_q[k] <= mem[addr[k]];
    end
  end

  // B0: fetch issued, keep request meta
  always_ff @(posedge clk_i) begin
    b0_err_q <= job_i.err;
    b0_row_q <= job_i.row;
    b0_col_q <= job_i.col;
    b0_rp_q  <= job_i.r0[0];
    b0_cp_q  <= job_i.c0[0];
    b0_wr_q  <= job_i.wr[WB-1:0];
    b0_wc_q  <= job_i.wc[WB-1:0];
  end

  // B1: horizontal blend per channel
  always_comb begin
    logic [PB-1:0] p00, p01, p10, p11;
    logic [WB-1:0] iwc;
    p00 = rdata_q[{b0_rp_q, b0_cp_q}];
    p01 = rdata_q[{b0_rp_q, ~b0_cp_q}];
    p10 = rdata_q[{~b0_rp_q, b0_cp_q}];
    p11 = rdata_q[{~b0_rp_q, ~b0_cp_q}];
    iwc = WOne - b0_wc_q;
    for (int ch = 0; ch < 3; ch++) begin
      top_d[ch] = TB'(iwc * p00[ch*SampleBits +: SampleBits]) +
                  TB'(b0_wc_q * p01[ch*SampleBits +: SampleBits]);
      bot_d[ch] = TB'(iwc * p10[ch*SampleBits +: SampleBits]) +
                  TB'(b0_wc_q * p11[ch*SampleBits +: SampleBits]);
    end
  end

  always_ff @(posedge clk_i) begin
    b1_err_q <= b0_err_q;
    b1_row_q <= b0_row_q;
    b1_col_q <= b0_col_q;
    b1_wr_q  <= b0_wr_q;
    for (int ch = 0; ch < 3; ch++) begin
      top_q[ch] <= top_d[ch];
      bot_q[ch] <= bot_d[ch];
    end
  end

  // B2: vertical blend, round, format result
  always_comb begin
    logic [WB-1:0] iwr;
    logic [SB-1:0] sum;
    iwr = WOne - b1_wr_q;
    for (int ch = 0; ch < 3; ch++) begin
      sum = SB'(iwr * top_q[ch]) + SB'(b1_wr_q * bot_q[ch]) + Half;
      blend[ch] = sum[2*WEIGHT_BITS +: SampleBits];
    end
    res_d.out_row     = b1_row_q;
    res_d.out_col     = b1_col_q;
    res_d.range_error = b1_err_q;
    res_d.out_a       = b1_err_q ? '0 : blend[0];
    res_d.out_b       = (b1_err_q || single_i) ? '0 : blend[1];
    res_d.out_c       = (b1_err_q || single_i) ? '0 : blend[2];
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b0_v_q   <= 1'b0;
      b1_v_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      b0_v_q   <= pop_o && !job_i.is_write;
      b1_v_q   <= b0_v_q;
      strobe_q <= b1_v_q;
    end
  end

  assign res_strobe_o = strobe_q;
  assign res_o        = res_q;

endmodule

// ----- rtl/core/bilinear_image_scaler.sv -----
// A request's result strobes for one cycle. Throughput: one beat per clock while busy
// is low; the four-bank frame store (row/column parity) serves either all four
// neighbors or one pixel write in a single cycle, one port per bank. Writes give no
// result. Reset clears control state and loads the register defaults; frame store
// contents are undefined until written. The receiver cannot stall results.
module bilinear_image_scaler #(
  parameter int unsigned MAX_SOURCE_ROWS = 256,
  parameter int unsigned MAX_SOURCE_COLS = 256,
  parameter int unsigned WEIGHT_BITS     = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  bis_pkg::item_t   item_i,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_idx_i,
  input  logic [23:0]      cfg_wdata_i,
  output logic             res_strobe_o,
  output bis_pkg::result_t res_o
);
  import bis_pkg::*;

  cfg_t cfg_q, cfg_d;
  logic push, q_full, q_empty, pop;
  job_t f_job, q_job;

  // Configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgSrcRows: cfg_d.source_rows    = cfg_wdata_i[8:0];
        CfgSrcCols: cfg_d.source_cols    = cfg_wdata_i[8:0];
        CfgDstRows: cfg_d.target_rows    = cfg_wdata_i[10:0];
        CfgDstCols: cfg_d.target_cols    = cfg_wdata_i[10:0];
        CfgRowStep: cfg_d.row_step       = cfg_wdata_i;
        CfgColStep: cfg_d.col_step       = cfg_wdata_i;
        CfgSingle:  cfg_d.single_channel = cfg_wdata_i[0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.source_rows    <= 9'd256;
      cfg_q.source_cols    <= 9'd256;
      cfg_q.target_rows    <= 11'd256;
      cfg_q.target_cols    <= 11'd256;
      cfg_q.row_step       <= 24'd65536;
      cfg_q.col_step       <= 24'd65536;
      cfg_q.single_channel <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  bis_front #(
    .MAX_SOURCE_ROWS(MAX_SOURCE_ROWS),
    .MAX_SOURCE_COLS(MAX_SOURCE_COLS),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start   (start),
    .busy    (busy),
    .item_i  (item_i),
    .cfg_i   (cfg_q),
    .q_full_i(q_full),
    .push_o  (push),
    .job_o   (f_job)
  );

  bis_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (f_job),
    .full_o (q_full),
    .pop_i  (pop),
    .empty_o(q_empty),
    .job_o  (q_job)
  );

  bis_back #(
    .MAX_SOURCE_ROWS(MAX_SOURCE_ROWS),
    .MAX_SOURCE_COLS(MAX_SOURCE_COLS),
    .WEIGHT_BITS    (WEIGHT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .empty_i     (q_empty),
    .job_i       (q_job),
    .pop_o       (pop),
    .single_i    (cfg_q.single_channel),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

  // The back end drains one job per cycle, so the queue never fills
  assert property (@(posedge clk_i) disable iff (!rst_ni) !q_full && !busy)
    else $error("job queue filled up");

  // A request beat gives its result a fixed time later
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.command == CmdRequest) |-> ##6 res_strobe_o)
    else $error("request result missing");

  // Out-of-range results carry zero samples
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && res_o.range_error) |->
      (res_o.out_a == '0 && res_o.out_b == '0 && res_o.out_c == '0))
    else $error("range error with nonzero samples");

  // Single channel mode leaves the second and third channels at zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_o && cfg_q.single_channel) |-> (res_o.out_b == '0 && res_o.out_c == '0))
    else $error("unused channels not zero");

endmodule
